// ----- rtl/core/vfdw_pkg.sv -----
// shared types, constants and a function for the frame store command writer
package vfdw_pkg;
    localparam int COLUMNS_DEF   = 140;
    localparam int BYTE_ROWS_DEF = 4;

    localparam logic [2:0] KIND_PIXEL   = 3'd0;
    localparam logic [2:0] KIND_FLUSH   = 3'd1;
    localparam logic [2:0] KIND_CLEAR   = 3'd2;
    localparam logic [2:0] KIND_ADVANCE = 3'd3;
    localparam logic [2:0] KIND_BRIGHT  = 3'd4;
    localparam logic [2:0] KIND_POWER   = 3'd5;

    // byte source selects for the datapath output mux
    typedef enum logic [3:0] {
        SRC_CONST = 4'd0,
        SRC_X     = 4'd1,
        SRC_ROW   = 4'd2,
        SRC_PIX   = 4'd3,
        SRC_LO    = 4'd4,
        SRC_LO_HI = 4'd5,
        SRC_W     = 4'd6,
        SRC_W_HI  = 4'd7,
        SRC_MEM   = 4'd8,
        SRC_BRT   = 4'd9
    } t_src;

    typedef struct packed {
        logic       emit;
        logic       last;
        t_src       src;
        logic [7:0] cbyte;
    } t_emit;

    // brightness code table (level*10+120)/125 for level 1..100
    function automatic logic [7:0] bright_code(input logic [7:0] level);
        logic [11:0] v;
        logic [7:0]  q;
        v = 12'(level) * 12'd10 + 12'd120;
        q = 8'd0;
        for (int k = 1; k <= 9; k++) begin
            if (v >= 12'(k * 125)) q = 8'(k);
        end
        return q;
    endfunction
endpackage

// ----- rtl/core/vfdw_ctrl.sv -----
// sequencer: walks each item through its byte list, the clear sweep and the zeroing pass after reset
module vfdw_ctrl #(
    parameter int COLUMNS   = vfdw_pkg::COLUMNS_DEF,
    parameter int BYTE_ROWS = vfdw_pkg::BYTE_ROWS_DEF,
    localparam int SIZE = COLUMNS * BYTE_ROWS,
    localparam int AW   = $clog2(SIZE + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [2:0]           i_kind,
    input  logic [7:0]           i_x_col,
    input  logic [7:0]           i_y_row,
    input  logic [7:0]           i_level,
    input  logic                 i_power_on,
    input  logic                 i_live,
    input  logic                 i_dirty_any,
    input  logic                 i_img_active,
    output logic                 o_busy,
    output logic                 o_pix_rd,
    output logic                 o_pix_wr,
    output logic                 o_flush_go,
    output logic                 o_adv_rd,
    output logic                 o_adv_done,
    output logic                 o_clr_init,
    output logic                 o_clr_rd,
    output logic                 o_init_wr,
    output logic [AW-1:0]        o_clr_addr,
    output vfdw_pkg::t_emit      o_emit
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_PRD   = 8'b00000010,
        S_PWR   = 8'b00000100,
        S_BYTES = 8'b00001000,
        S_ADV   = 8'b00010000,
        S_CLR   = 8'b00100000,
        S_CLRE  = 8'b01000000,
        S_INIT  = 8'b10000000
    } t_state;

    t_state        r_state, n_state;
    logic [2:0]    r_kind;
    logic [7:0]    r_level;
    logic          r_pwr;
    logic [3:0]    r_cnt, n_cnt;
    logic [3:0]    r_nb;
    logic [AW-1:0] r_addr, n_addr;
    logic          pix_ok;

    assign pix_ok = (i_x_col < 8'(COLUMNS)) && (9'(i_y_row) < 9'(8 * BYTE_ROWS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && r_state == S_IDLE) begin
            r_kind  <= i_kind;
            r_level <= i_level;
            r_pwr   <= i_power_on;
            case (i_kind)
                vfdw_pkg::KIND_PIXEL:  r_nb <= 4'd15;
                vfdw_pkg::KIND_FLUSH:  r_nb <= 4'd14;
                vfdw_pkg::KIND_POWER:  r_nb <= 4'd4;
                vfdw_pkg::KIND_BRIGHT: r_nb <= (i_level == 8'd0) ? 4'd4 : 4'd7;
                default:               r_nb <= 4'd0;
            endcase
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_addr     = r_addr;
        o_pix_rd   = 1'b0;
        o_pix_wr   = 1'b0;
        o_flush_go = 1'b0;
        o_adv_rd   = 1'b0;
        o_adv_done = 1'b0;
        o_clr_init = 1'b0;
        o_clr_rd   = 1'b0;
        o_init_wr  = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    case (i_kind)
                        vfdw_pkg::KIND_PIXEL: begin
                            if (pix_ok) n_state = S_PRD;
                        end
                        vfdw_pkg::KIND_FLUSH: begin
                            if (i_dirty_any) begin
                                o_flush_go = 1'b1;
                                n_state    = S_BYTES;
                            end
                        end
                        vfdw_pkg::KIND_CLEAR: begin
                            o_clr_init = 1'b1;
                            n_addr     = '0;
                            n_state    = S_CLR;
                        end
                        vfdw_pkg::KIND_ADVANCE: begin
                            if (i_img_active) begin
                                o_adv_rd = 1'b1;
                                n_state  = S_ADV;
                            end
                        end
                        vfdw_pkg::KIND_BRIGHT: begin
                            if (i_level <= 8'd100) n_state = S_BYTES;
                        end
                        vfdw_pkg::KIND_POWER: n_state = S_BYTES;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_PRD: begin
                // pixel address registers are loaded now
                o_pix_rd = 1'b1;
                n_state  = S_PWR;
            end
            S_PWR: begin
                o_pix_wr = 1'b1;
                n_state  = i_live ? S_BYTES : S_IDLE;
            end
            S_BYTES: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == r_nb) n_state = S_IDLE;
            end
            S_ADV: begin
                o_adv_done = 1'b1;
                n_state    = S_IDLE;
            end
            S_CLR: begin
                // one store byte read and zeroed per cycle
                o_clr_rd = 1'b1;
                n_addr   = r_addr + AW'(1);
                if (r_addr == AW'(SIZE - 1)) n_state = S_CLRE;
            end
            S_CLRE: n_state = S_IDLE;
            S_INIT: begin
                // zeroing pass after reset, one byte per cycle
                o_init_wr = 1'b1;
                n_addr    = r_addr + AW'(1);
                if (r_addr == AW'(SIZE - 1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_clr_addr = r_addr;
    assign o_busy     = (r_state != S_IDLE);

    always_comb begin
        o_emit       = '0;
        o_emit.src   = vfdw_pkg::SRC_CONST;
        if (r_state == S_ADV) begin
            o_emit.emit = 1'b1;
            o_emit.last = 1'b1;
            o_emit.src  = vfdw_pkg::SRC_MEM;
        end else if (r_state == S_BYTES) begin
            o_emit.emit = 1'b1;
            o_emit.last = (r_cnt == r_nb);
            case (r_kind)
                vfdw_pkg::KIND_PIXEL: begin
                    case (r_cnt)
                        4'd0, 4'd6: o_emit.cbyte = 8'h1F;
                        4'd1: o_emit.cbyte = 8'h24;
                        4'd2: o_emit.src = vfdw_pkg::SRC_X;
                        4'd4: o_emit.src = vfdw_pkg::SRC_ROW;
                        4'd7: o_emit.cbyte = 8'h28;
                        4'd8: o_emit.cbyte = 8'h66;
                        4'd9: o_emit.cbyte = 8'h11;
                        4'd10, 4'd12, 4'd14: o_emit.cbyte = 8'h01;
                        4'd15: o_emit.src = vfdw_pkg::SRC_PIX;
                        default: o_emit.cbyte = 8'h00;
                    endcase
                end
                vfdw_pkg::KIND_FLUSH: begin
                    case (r_cnt)
                        4'd0, 4'd6: o_emit.cbyte = 8'h1F;
                        4'd1: o_emit.cbyte = 8'h24;
                        4'd2: o_emit.src = vfdw_pkg::SRC_LO;
                        4'd3: o_emit.src = vfdw_pkg::SRC_LO_HI;
                        4'd7: o_emit.cbyte = 8'h28;
                        4'd8: o_emit.cbyte = 8'h66;
                        4'd9: o_emit.cbyte = 8'h11;
                        4'd10: o_emit.src = vfdw_pkg::SRC_W;
                        4'd11: o_emit.src = vfdw_pkg::SRC_W_HI;
                        4'd12: o_emit.cbyte = 8'(BYTE_ROWS);
                        4'd14: o_emit.cbyte = 8'h01;
                        default: o_emit.cbyte = 8'h00;
                    endcase
                end
                default: begin
                    case (r_cnt)
                        4'd0, 4'd5: o_emit.cbyte = 8'h1F;
                        4'd1: o_emit.cbyte = 8'h28;
                        4'd2: o_emit.cbyte = 8'h61;
                        4'd3: o_emit.cbyte = 8'h40;
                        4'd4: o_emit.cbyte = (r_kind == vfdw_pkg::KIND_POWER) ?
                                  {7'd0, r_pwr} : {7'd0, (r_level != 8'd0)};
                        4'd6: o_emit.cbyte = 8'h58;
                        4'd7: o_emit.src = vfdw_pkg::SRC_BRT;
                        default: o_emit.cbyte = 8'h00;
                    endcase
                end
            endcase
        end
    end
endmodule

// ----- rtl/core/vfdw_dp.sv -----
// datapath: frame store memory, dirty span, image stream pointers, output byte
module vfdw_dp #(
    parameter int COLUMNS   = vfdw_pkg::COLUMNS_DEF,
    parameter int BYTE_ROWS = vfdw_pkg::BYTE_ROWS_DEF,
    localparam int SIZE = COLUMNS * BYTE_ROWS,
    localparam int AW   = $clog2(SIZE + 1),
    localparam int IW   = $clog2(SIZE),
    localparam int RW   = (BYTE_ROWS > 1) ? $clog2(BYTE_ROWS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start_idle,
    input  logic [7:0]       i_x_col,
    input  logic [7:0]       i_y_row,
    input  logic             i_pixel_on,
    input  logic [7:0]       i_extend,
    input  logic [7:0]       i_level,
    input  logic             i_pix_rd,
    input  logic             i_pix_wr,
    input  logic             i_flush_go,
    input  logic             i_adv_rd,
    input  logic             i_adv_done,
    input  logic             i_clr_init,
    input  logic             i_clr_rd,
    input  logic             i_init_wr,
    input  logic [AW-1:0]    i_clr_addr,
    input  vfdw_pkg::t_emit  i_emit,
    output logic             o_dirty_any,
    output logic             o_img_active,
    output logic             o_strobe,
    output logic [7:0]       o_out_byte,
    output logic             o_last,
    output logic             o_image_pending
);
    logic [7:0]    r_mem [SIZE];
    logic [7:0]    r_rdata;
    logic          r_dirty_any;
    logic [7:0]    r_dlo, r_dhi;
    logic [AW-1:0] r_img_next, r_img_stop;
    logic          r_img_active;
    logic [7:0]    r_x, r_y, r_brt;
    logic          r_on;
    logic [8:0]    r_lo, r_w;
    logic [7:0]    r_ccol, r_clr_col;
    logic [RW-1:0] r_crow;
    logic          r_clr_v;
    logic [AW-1:0] pix_addr, rd_addr;
    logic [7:0]    pix_mask, pix_new;
    logic [9:0]    hi_raw, hi_cl;
    logic [8:0]    lo_cl;
    logic [AW-1:0] img_inc;
    logic [7:0]    clr_col;

    assign pix_addr = AW'(r_x) * AW'(BYTE_ROWS) + AW'(r_y[7:3]);
    assign pix_mask = 8'h80 >> r_y[2:0];
    assign pix_new  = r_on ? (r_rdata | pix_mask) : (r_rdata & ~pix_mask);
    assign rd_addr  = i_clr_rd ? i_clr_addr : (i_adv_rd ? r_img_next : pix_addr);
    assign img_inc  = r_img_next + AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_start_idle) begin
            r_x   <= i_x_col;
            r_y   <= i_y_row;
            r_on  <= i_pixel_on;
            r_brt <= vfdw_pkg::bright_code(i_level);
        end
    end

    // single port store: one read or one write per cycle, or a read and zeroing of the same byte
    always_ff @(posedge i_clk) begin
        if (i_pix_wr) begin
            r_mem[pix_addr[IW-1:0]] <= pix_new;
        end else if (i_clr_rd || i_init_wr) begin
            r_mem[i_clr_addr[IW-1:0]] <= 8'h00;
        end
        if (i_clr_rd || i_adv_rd || i_pix_rd) begin
            r_rdata <= (rd_addr < AW'(SIZE)) ? r_mem[rd_addr[IW-1:0]] : 8'h00;
        end
    end

    // column of the byte read by the clear sweep, registered together with the read data
    always_ff @(posedge i_clk) begin
        if (i_clr_init) begin
            r_ccol <= '0;
            r_crow <= '0;
        end else if (i_clr_rd) begin
            r_clr_col <= r_ccol;
            if (r_crow == RW'(BYTE_ROWS - 1)) begin
                r_crow <= '0;
                r_ccol <= r_ccol + 8'd1;
            end else begin
                r_crow <= r_crow + RW'(1);
            end
        end
    end

    assign clr_col = r_clr_col;

    assign hi_raw = 10'(r_dhi) + 10'(i_extend) + 10'd1;
    assign hi_cl  = (hi_raw > 10'(COLUMNS)) ? 10'(COLUMNS) : hi_raw;
    assign lo_cl  = (r_dlo >= i_extend) ? 9'(r_dlo - i_extend) : 9'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty_any  <= 1'b0;
            r_dlo        <= '0;
            r_dhi        <= '0;
            r_img_next   <= '0;
            r_img_stop   <= '0;
            r_img_active <= 1'b0;
            r_clr_v      <= 1'b0;
            o_strobe     <= 1'b0;
        end else begin
            r_clr_v  <= i_clr_rd;
            o_strobe <= i_emit.emit;
            if (i_pix_wr) begin
                if (!r_dirty_any) begin
                    r_dirty_any <= 1'b1;
                    r_dlo <= r_x;
                    r_dhi <= r_x;
                end else begin
                    if (r_x < r_dlo) r_dlo <= r_x;
                    if (r_x > r_dhi) r_dhi <= r_x;
                end
            end
            if (i_flush_go) begin
                r_dirty_any  <= 1'b0;
                r_dlo        <= '0;
                r_dhi        <= '0;
                r_lo         <= lo_cl;
                r_w          <= 9'(hi_cl - 10'(lo_cl));
                r_img_next   <= AW'(lo_cl) * AW'(BYTE_ROWS);
                r_img_stop   <= AW'(hi_cl) * AW'(BYTE_ROWS);
                r_img_active <= 1'b1;
            end
            if (i_adv_done) begin
                r_img_next <= img_inc;
                if (img_inc >= r_img_stop) r_img_active <= 1'b0;
            end
            if (i_clr_init) begin
                r_dirty_any <= 1'b0;
                r_dlo       <= '0;
                r_dhi       <= '0;
            end
            if (r_clr_v && r_rdata != 8'h00) begin
                if (!r_dirty_any) begin
                    r_dirty_any <= 1'b1;
                    r_dlo <= clr_col;
                    r_dhi <= clr_col;
                end else begin
                    if (clr_col < r_dlo) r_dlo <= clr_col;
                    if (clr_col > r_dhi) r_dhi <= clr_col;
                end
            end
        end
    end

    // output byte register
    always_ff @(posedge i_clk) begin
        o_last          <= i_emit.last;
        o_image_pending <= i_adv_done ? (img_inc < r_img_stop) : r_img_active;
        case (i_emit.src)
            vfdw_pkg::SRC_X:     o_out_byte <= r_x;
            vfdw_pkg::SRC_ROW:   o_out_byte <= {3'd0, r_y[7:3]};
            vfdw_pkg::SRC_PIX:   o_out_byte <= pix_new;
            vfdw_pkg::SRC_LO:    o_out_byte <= r_lo[7:0];
            vfdw_pkg::SRC_LO_HI: o_out_byte <= {7'd0, r_lo[8]};
            vfdw_pkg::SRC_W:     o_out_byte <= r_w[7:0];
            vfdw_pkg::SRC_W_HI:  o_out_byte <= {7'd0, r_w[8]};
            vfdw_pkg::SRC_MEM:   o_out_byte <= r_rdata;
            vfdw_pkg::SRC_BRT:   o_out_byte <= r_brt;
            default:             o_out_byte <= i_emit.cbyte;
        endcase
    end

    assign o_dirty_any  = r_dirty_any;
    assign o_img_active = r_img_active;
endmodule

// ----- rtl/core/vfd_frame_store_command_writer.sv -----
// top level: frame store command writer for a 140x32 vfd panel
// the first byte passes the state register and the output byte register (a pixel write
//   first reads and writes the store in S_PRD and S_PWR), then one byte per cycle; a new
//   item is taken only while idle; clear sweeps the whole store
// the store is a single-port memory; busy drops as the item's last byte goes out
// reset is synchronous, active low; then busy while the zeroing pass clears the store
module vfd_frame_store_command_writer #(
    parameter int COLUMNS   = vfdw_pkg::COLUMNS_DEF,
    parameter int BYTE_ROWS = vfdw_pkg::BYTE_ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_x_col,
    input  logic [7:0] i_y_row,
    input  logic       i_pixel_on,
    input  logic [7:0] i_extend,
    input  logic [7:0] i_level,
    input  logic       i_power_on,
    output logic       o_strobe,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic       o_image_pending
);
    localparam int SIZE = COLUMNS * BYTE_ROWS;
    localparam int AW   = $clog2(SIZE + 1);

    logic            r_live;
    logic            pix_rd, pix_wr, flush_go, adv_rd, adv_done, clr_init, clr_rd;
    logic            init_wr;
    logic [AW-1:0]   clr_addr;
    logic            dirty_any, img_active;
    vfdw_pkg::t_emit emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_live <= 1'b1;
        else if (i_cfg_we) r_live <= i_cfg_wdata;
    end

    vfdw_ctrl #(.COLUMNS(COLUMNS), .BYTE_ROWS(BYTE_ROWS)) u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_kind, .i_x_col, .i_y_row,
        .i_level, .i_power_on, .i_live(r_live), .i_dirty_any(dirty_any),
        .i_img_active(img_active), .o_busy(busy), .o_pix_rd(pix_rd),
        .o_pix_wr(pix_wr), .o_flush_go(flush_go), .o_adv_rd(adv_rd),
        .o_adv_done(adv_done), .o_clr_init(clr_init), .o_clr_rd(clr_rd),
        .o_init_wr(init_wr), .o_clr_addr(clr_addr), .o_emit(emit)
    );

    vfdw_dp #(.COLUMNS(COLUMNS), .BYTE_ROWS(BYTE_ROWS)) u_dp (
        .i_clk, .i_rst_n, .i_start_idle(start && !busy), .i_x_col, .i_y_row,
        .i_pixel_on, .i_extend, .i_level, .i_pix_rd(pix_rd), .i_pix_wr(pix_wr),
        .i_flush_go(flush_go), .i_adv_rd(adv_rd), .i_adv_done(adv_done),
        .i_clr_init(clr_init), .i_clr_rd(clr_rd), .i_init_wr(init_wr),
        .i_clr_addr(clr_addr),
        .i_emit(emit), .o_dirty_any(dirty_any), .o_img_active(img_active),
        .o_strobe, .o_out_byte, .o_last, .o_image_pending
    );

    a_flush_clears_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flush_go |=> !dirty_any) else $error("span not emptied by flush");
    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe) else $error("byte after last");
    a_adv_needs_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_rd |-> img_active) else $error("advance with no stream");
endmodule

// ----- bench/vfd_frame_store_command_checker.sv -----
// checker for the frame store command writer: predicts command bytes and compares
`timescale 1ns / 1ps
module vfd_frame_store_command_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_x_col,
    input  logic [7:0] i_y_row,
    input  logic       i_pixel_on,
    input  logic [7:0] i_extend,
    input  logic [7:0] i_level,
    input  logic       i_power_on,
    input  logic       o_strobe,
    input  logic [7:0] o_out_byte,
    input  logic       o_last,
    input  logic       o_image_pending,
    output int         o_fail_count,
    output int         o_pending_words
);
    localparam int NCOL = vfdw_pkg::COLUMNS_DEF;
    localparam int NROW = vfdw_pkg::BYTE_ROWS_DEF;
    localparam int STORE_BYTES = NCOL * NROW;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pending;
    } t_word;

    t_word      expected_words[$];
    t_word      item_words[$];
    logic [7:0] pixels[STORE_BYTES];
    logic       span_valid;
    logic [7:0] span_low, span_high;
    int         stream_next, stream_stop;
    logic       stream_on;
    logic       live;

    assign o_pending_words = expected_words.size();

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    function automatic void push_word(input int b);
        t_word w;
        w.data = 8'(b);
        w.last = 1'b0;
        w.pending = stream_on;
        item_words.push_back(w);
    endfunction

    function automatic void widen_span(input logic [7:0] c);
        if (!span_valid) begin
            span_valid = 1'b1;
            span_low = c;
            span_high = c;
        end else begin
            if (c < span_low) span_low = c;
            if (c > span_high) span_high = c;
        end
    endfunction

    function automatic void display_power(input logic on);
        push_word(8'h1F); push_word(8'h28); push_word(8'h61); push_word(8'h40);
        push_word(on);
    endfunction

    function automatic void predict_command(input logic [2:0] kind, input logic [7:0] x,
        input logic [7:0] y, input logic on, input logic [7:0] ext, input logic [7:0] lvl,
        input logic pwr);
        int idx, hi, lo, w;
        logic [7:0] b;
        item_words.delete();
        case (kind)
            vfdw_pkg::KIND_PIXEL: begin
                if (x < NCOL && y < 8 * NROW) begin
                    idx = x * NROW + (y >> 3);
                    b = pixels[idx];
                    if (on) b = b | (8'h80 >> y[2:0]);
                    else b = b & ~(8'h80 >> y[2:0]);
                    pixels[idx] = b;
                    widen_span(x);
                    if (live) begin
                        push_word(8'h1F); push_word(8'h24); push_word(x); push_word(0);
                        push_word(y >> 3); push_word(0);
                        push_word(8'h1F); push_word(8'h28); push_word(8'h66);
                        push_word(8'h11); push_word(1); push_word(0); push_word(1);
                        push_word(0); push_word(1); push_word(b);
                    end
                end
            end
            vfdw_pkg::KIND_FLUSH: begin
                if (span_valid) begin
                    hi = span_high + ext + 1;
                    lo = (span_low >= ext) ? span_low - ext : 0;
                    if (hi > NCOL) hi = NCOL;
                    w = hi - lo;
                    span_valid = 1'b0;
                    span_low = 0;
                    span_high = 0;
                    stream_next = lo * NROW;
                    stream_stop = hi * NROW;
                    stream_on = 1'b1;
                    push_word(8'h1F); push_word(8'h24); push_word(lo); push_word(lo >> 8);
                    push_word(0); push_word(0);
                    push_word(8'h1F); push_word(8'h28); push_word(8'h66); push_word(8'h11);
                    push_word(w); push_word(w >> 8); push_word(NROW); push_word(0);
                    push_word(1);
                end
            end
            vfdw_pkg::KIND_CLEAR: begin
                span_valid = 1'b0;
                span_low = 0;
                span_high = 0;
                for (int c = 0; c < NCOL; c++)
                    for (int r = 0; r < NROW; r++)
                        if (pixels[c * NROW + r] != 0) widen_span(8'(c));
                foreach (pixels[i]) pixels[i] = 8'h00;
            end
            vfdw_pkg::KIND_ADVANCE: begin
                if (stream_on) begin
                    b = (stream_next < STORE_BYTES) ? pixels[stream_next] : 8'h00;
                    stream_next++;
                    if (stream_next >= stream_stop) stream_on = 1'b0;
                    push_word(b);
                end
            end
            vfdw_pkg::KIND_BRIGHT: begin
                if (lvl == 0) display_power(1'b0);
                else if (lvl <= 100) begin
                    display_power(1'b1);
                    push_word(8'h1F); push_word(8'h58); push_word((lvl * 10 + 120) / 125);
                end
            end
            vfdw_pkg::KIND_POWER: display_power(pwr);
            default: ;
        endcase
        if (item_words.size() > 0) item_words[item_words.size() - 1].last = 1'b1;
        foreach (item_words[i]) expected_words.push_back(item_words[i]);
    endfunction

    always @(posedge i_clk) begin
        t_word e;
        if (!i_rst_n) begin
            foreach (pixels[i]) pixels[i] = 8'h00;
            span_valid = 1'b0;
            span_low = 0;
            span_high = 0;
            stream_next = 0;
            stream_stop = 0;
            stream_on = 1'b0;
            live = 1'b1;
            expected_words.delete();
            o_fail_count = 0;
        end else begin
            // result before the new item: the block cannot emit in the accept cycle
            if (o_strobe) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %02h", o_out_byte));
                end else begin
                    e = expected_words.pop_front();
                    if (o_out_byte !== e.data)
                        report_mismatch($sformatf("byte %02h, want %02h", o_out_byte, e.data));
                    if (o_last !== e.last)
                        report_mismatch($sformatf("last %b, want %b", o_last, e.last));
                    if (o_image_pending !== e.pending)
                        report_mismatch($sformatf("image_pending %b, want %b",
                            o_image_pending, e.pending));
                end
            end
            if (i_cfg_we) live = i_cfg_wdata;
            if (start && !busy)
                predict_command(i_kind, i_x_col, i_y_row, i_pixel_on, i_extend, i_level,
                    i_power_on);
        end
    end
endmodule

// ----- bench/tb_vfd_frame_store_command_writer.sv -----
// testbench top: drives command items and register writes, reports the verdict
`timescale 1ns / 1ps
module tb_vfd_frame_store_command_writer;
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic [2:0] i_kind = '0;
    logic [7:0] i_x_col = '0, i_y_row = '0, i_extend = '0, i_level = '0;
    logic       i_pixel_on = 1'b0, i_power_on = 1'b0;
    logic       o_strobe, o_last, o_image_pending;
    logic [7:0] o_out_byte;
    int         fail_count, pending_words;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    vfd_frame_store_command_writer dut (.*);

    vfd_frame_store_command_checker checker_i (.*, .o_fail_count(fail_count),
        .o_pending_words(pending_words));

    // start stays high into the next item when there is no gap
    task automatic send_command(input logic [2:0] kind, input logic [7:0] x,
        input logic [7:0] y, input logic on, input logic [7:0] ext, input logic [7:0] lvl,
        input logic pwr, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_kind <= kind; i_x_col <= x; i_y_row <= y; i_pixel_on <= on;
        i_extend <= ext; i_level <= lvl; i_power_on <= pwr;
        do @(posedge i_clk); while (busy);
    endtask

    // wait until every expected word is out, then let a clear sweep finish
    task automatic drain_words();
        start <= 1'b0;
        while (pending_words != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_live(input logic v);
        drain_words();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_command();
        int r;
        logic [2:0] k;
        logic [7:0] x, y;
        r = $urandom_range(0, 99);
        if (r < 45) k = vfdw_pkg::KIND_PIXEL;
        else if (r < 53) k = vfdw_pkg::KIND_FLUSH;
        else if (r < 56) k = vfdw_pkg::KIND_CLEAR;
        else if (r < 86) k = vfdw_pkg::KIND_ADVANCE;
        else if (r < 92) k = vfdw_pkg::KIND_BRIGHT;
        else if (r < 97) k = vfdw_pkg::KIND_POWER;
        else k = 3'($urandom_range(6, 7));
        // mostly on-panel pixels, some off the edge
        x = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 139));
        y = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
        send_command(k, x, y, 1'($urandom), ($urandom_range(0, 3) == 0) ? 8'($urandom)
            : 8'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0) ? 8'($urandom)
            : 8'($urandom_range(0, 100)), 1'($urandom),
            ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 8)));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: corners, off-panel, each kind, brightness edges
        send_command(vfdw_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0);
        send_command(vfdw_pkg::KIND_FLUSH, 0, 0, 0, 0, 0, 0, 0);
        send_command(vfdw_pkg::KIND_PIXEL, 0, 0, 1, 0, 0, 0, 0);
        send_command(vfdw_pkg::KIND_PIXEL, 139, 31, 1, 0, 0, 0, 1);
        send_command(vfdw_pkg::KIND_PIXEL, 139, 31, 1, 0, 0, 0, 0);
        send_command(vfdw_pkg::KIND_PIXEL, 140, 5, 1, 0, 0, 0, 0);
        send_command(vfdw_pkg::KIND_PIXEL, 255, 255, 1, 0, 0, 0, 0);
        send_command(vfdw_pkg::KIND_PIXEL, 3, 32, 1, 0, 0, 0, 0);
        send_command(vfdw_pkg::KIND_PIXEL, 0, 0, 0, 255, 255, 1, 2);
        send_command(vfdw_pkg::KIND_FLUSH, 0, 0, 0, 255, 0, 0, 0);
        send_command(vfdw_pkg::KIND_POWER, 0, 0, 0, 0, 0, 1, 0);
        for (int i = 0; i < 5; i++)
            send_command(vfdw_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 3);
        send_command(vfdw_pkg::KIND_PIXEL, 70, 9, 1, 0, 0, 0, 0);
        send_command(vfdw_pkg::KIND_FLUSH, 0, 0, 0, 0, 0, 0, 0);
        send_command(vfdw_pkg::KIND_BRIGHT, 0, 0, 0, 0, 0, 0, 0);
        send_command(vfdw_pkg::KIND_BRIGHT, 0, 0, 0, 0, 1, 0, 0);
        send_command(vfdw_pkg::KIND_BRIGHT, 0, 0, 0, 0, 100, 0, 0);
        send_command(vfdw_pkg::KIND_BRIGHT, 0, 0, 0, 0, 101, 0, 0);
        send_command(vfdw_pkg::KIND_POWER, 0, 0, 0, 0, 0, 0, 0);
        send_command(vfdw_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        send_command(3'd6, 0, 0, 0, 0, 0, 0, 0);
        send_command(3'd7, 0, 0, 0, 0, 0, 0, 0);
        write_live(1'b0);
        send_command(vfdw_pkg::KIND_PIXEL, 12, 20, 1, 0, 0, 0, 0);
        send_command(vfdw_pkg::KIND_FLUSH, 0, 0, 0, 1, 0, 0, 0);
        send_command(vfdw_pkg::KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0);
        // random phases, toggling the register between them
        for (int p = 0; p < 4; p++) begin
            write_live(p[0]);
            for (int i = 0; i < 72; i++) begin
                random_command();
                if (i == 40) drain_words();
            end
        end
        drain_words();
        if (fail_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/vfdw_pkg.sv
rtl/core/vfdw_ctrl.sv
rtl/core/vfdw_dp.sv
rtl/core/vfd_frame_store_command_writer.sv
bench/vfd_frame_store_command_checker.sv
bench/tb_vfd_frame_store_command_writer.sv
